[hw/rtl/cfq_pkg.sv]
`timescale 1ns / 1ps

package cfq_pkg;

  localparam int DATA_W     = 32;
  localparam int CNT_W      = 5;
  localparam int CAP_W      = 5;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int DEPTH_DEF  = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [FUNC_W-1:0] FUNC_ENQ   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] item_value;
  } cfq_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   out_value;
    logic [DATA_W-1:0]   front_value;
    logic [DATA_W-1:0]   rear_value;
    logic [CNT_W-1:0]    count;
  } cfq_out_t;

  // Per-cell read selects: slot leaving on dequeue, new front, new rear
  typedef struct packed {
    logic deq;
    logic front;
    logic rear;
  } cfq_hit_t;

  // Read words collected along the cell chain
  typedef struct packed {
    logic [DATA_W-1:0] deq;
    logic [DATA_W-1:0] front;
    logic [DATA_W-1:0] rear;
  } cfq_rd_t;

endpackage

[hw/rtl/circular_fifo_queue.sv]
`timescale 1ns / 1ps

// Circular FIFO of data words built as a row of storage cells.
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one operation:
// enqueue, dequeue or query. Each transfer yields exactly one result on the
// output channel (out_valid_o/out_ready_i/out_data_o): status, dequeued word,
// front and rear words after the operation, and the fill count.
// The result is valid in the cycle after the input transfer; one operation is
// taken every cycle as long as the output register is empty or being drained.
// Slot reads run as an OR chain through the cells, selected by head and tail.
// The config channel writes the capacity (wrap point of both indices); it is
// always ready and should only be written while no operation is in flight.
// Reset empties the queue, sets capacity to 16 and drops any pending result;
// stored words are not cleared. If the receiver stalls, the result holds and
// in_ready_o drops until it is taken.
module circular_fifo_queue #(
  parameter int DEPTH = cfq_pkg::DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  cfq_pkg::cfq_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output cfq_pkg::cfq_out_t         out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [cfq_pkg::CAP_W-1:0] cfg_data_i
);
  import cfq_pkg::*;

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [CAP_W-1:0] cap_q;
  logic [IdxW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic             out_valid_q;
  cfq_out_t         out_q, out_d;

  logic [CntW-1:0]  cap_eff;
  logic             take, is_enq, is_deq, is_full, is_empty, do_wr, do_rd;
  logic [IdxW-1:0]  wr_pos;
  cfq_rd_t          chain [DEPTH+1];

  function automatic logic [IdxW-1:0] advance(input logic [IdxW-1:0] idx,
                                              input logic [CntW-1:0] cap);
    logic [IdxW:0] n;
    n = {1'b0, idx} + (IdxW+1)'(1);
    if (32'(n) >= 32'(cap)) begin
      return '0;
    end
    return n[IdxW-1:0];
  endfunction

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CntW'(1);
    end else if (32'(cap_q) > DEPTH) begin
      cap_eff = CntW'(DEPTH);
    end else begin
      cap_eff = CntW'(cap_q);
    end
  end

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign is_enq   = (in_data_i.func == FUNC_ENQ);
  assign is_deq   = (in_data_i.func == FUNC_DEQ);
  assign is_full  = (fill_q >= cap_eff);
  assign is_empty = (fill_q == '0);
  assign do_wr    = is_enq && !is_full;
  assign do_rd    = is_deq && !is_empty;
  assign wr_pos   = is_empty ? '0 : advance(tail_q, cap_eff);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (do_wr) begin
      tail_d = wr_pos;
      fill_d = fill_q + CntW'(1);
      if (is_empty) begin
        head_d = '0;
      end
    end else if (do_rd) begin
      fill_d = fill_q - CntW'(1);
      if (fill_q == CntW'(1)) begin
        head_d = '0;
        tail_d = '0;
      end else begin
        head_d = advance(head_q, cap_eff);
      end
    end
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cfq_hit_t hit;
    assign hit.deq   = (head_q == IdxW'(i));
    assign hit.front = (head_d == IdxW'(i));
    assign hit.rear  = (tail_d == IdxW'(i));

    cfq_cell u_cell (
      .clk_i     (clk_i),
      .wr_en_i   (take && do_wr && (wr_pos == IdxW'(i))),
      .wr_data_i (in_data_i.item_value),
      .hit_i     (hit),
      .chain_i   (chain[i]),
      .chain_o   (chain[i+1])
    );
  end

  // Word written in this transfer is not in the cell yet: bypass it
  // (after a capacity shrink the write can land on the front slot)
  always_comb begin
    out_d.status      = ST_OK;
    out_d.out_value   = '0;
    out_d.front_value = '0;
    out_d.rear_value  = '0;
    out_d.count       = CNT_W'(fill_d);
    if (is_enq && is_full) begin
      out_d.status = ST_FULL;
    end else if (is_deq && is_empty) begin
      out_d.status = ST_EMPTY;
    end
    if (do_rd) begin
      out_d.out_value = chain[DEPTH].deq;
    end
    if (fill_d != '0) begin
      out_d.front_value = (do_wr && (wr_pos == head_d)) ? in_data_i.item_value
                                                        : chain[DEPTH].front;
      out_d.rear_value  = do_wr ? in_data_i.item_value : chain[DEPTH].rear;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (take) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hw/rtl/cfq_cell.sv]
`timescale 1ns / 1ps

module cfq_cell (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [cfq_pkg::DATA_W-1:0] wr_data_i,
  input  cfq_pkg::cfq_hit_t        hit_i,
  input  cfq_pkg::cfq_rd_t         chain_i,
  output cfq_pkg::cfq_rd_t         chain_o
);
  import cfq_pkg::*;

  logic [DATA_W-1:0] word_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      word_q <= wr_data_i;
    end
  end

  // Only the selected cell contributes; the rest pass the neighbor's word on
  always_comb begin
    chain_o.deq   = chain_i.deq   | (hit_i.deq   ? word_q : '0);
    chain_o.front = chain_i.front | (hit_i.front ? word_q : '0);
    chain_o.rear  = chain_i.rear  | (hit_i.rear  ? word_q : '0);
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import cfq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  // func code 3 is not defined by the block; it must behave as a query
  localparam logic [FUNC_W-1:0] FUNC_RSVD = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_ITEMS = 1000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  cfq_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cfq_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  circular_fifo_queue #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Queue model state
  logic [DATA_W-1:0] model_slots [DEPTH];
  int unsigned model_head = 0;
  int unsigned model_tail = 0;
  int unsigned model_fill = 0;
  logic [CAP_W-1:0] model_cap = CAP_RESET;

  cfq_out_t pending_results[$];
  cfq_out_t next_expected;
  int unsigned err_cnt = 0;
  int unsigned result_num = 0;
  int unsigned stall_left = 0;
  bit no_idle = 1'b0;

  function automatic int unsigned next_slot(int unsigned idx, int unsigned cap);
    int unsigned n;
    n = idx + 1;
    return (n >= cap || n >= DEPTH) ? 0 : n;
  endfunction

  // Applies one operation to the model and returns the result it should give
  function automatic cfq_out_t fifo_apply(cfq_in_t op);
    int unsigned cap;
    int unsigned pos;
    cfq_out_t r;
    cap = (model_cap == 0) ? 1 : ((model_cap > DEPTH) ? DEPTH : model_cap);
    r = '0;
    r.status = ST_OK;
    if (op.func == FUNC_ENQ) begin
      if (model_fill >= cap) begin
        r.status = ST_FULL;
      end else begin
        pos = (model_fill == 0) ? 0 : next_slot(model_tail, cap);
        model_slots[pos] = op.item_value;
        model_tail = pos;
        if (model_fill == 0) model_head = 0;
        model_fill++;
      end
    end else if (op.func == FUNC_DEQ) begin
      if (model_fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.out_value = model_slots[model_head];
        model_head = next_slot(model_head, cap);
        model_fill--;
        if (model_fill == 0) begin
          model_head = 0;
          model_tail = 0;
        end
      end
    end
    if (model_fill != 0) begin
      r.front_value = model_slots[model_head];
      r.rear_value = model_slots[model_tail];
    end
    r.count = model_fill[CNT_W-1:0];
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] exp_v,
                                      logic [DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("result %0d: %s mismatch, expected %h, actual %h",
                 result_num, name, exp_v, act_v);
    end
  endfunction

  task automatic send_op(logic [FUNC_W-1:0] func, logic [DATA_W-1:0] value);
    cfq_in_t op;
    op.func = func;
    op.item_value = value;
    if (!no_idle && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= op;
    do @(posedge clk_i); while (!in_ready);
    pending_results.push_back(fifo_apply(op));
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk_i); while (!cfg_ready);
    model_cap = cap;
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Empty-queue ops, then fill every slot once so later capacity changes
  // never expose an unwritten slot
  task automatic test_fill_all_slots();
    send_op(FUNC_DEQ, '1);
    send_op(FUNC_QUERY, '1);
    for (int i = 0; i < DEPTH; i++) begin
      send_op(FUNC_ENQ, (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF :
                        (i == 2) ? 32'h8000_0001 : $urandom);
    end
    send_op(FUNC_ENQ, 32'hDEAD_BEEF);
    send_op(FUNC_RSVD, $urandom);
  endtask

  // Capacity shrunk below the fill level, then out-of-range values
  task automatic test_capacity_with_data();
    wait_results_drained();
    write_capacity(5'd4);
    send_op(FUNC_ENQ, $urandom);
    send_op(FUNC_DEQ, $urandom);
    send_op(FUNC_DEQ, $urandom);
    send_op(FUNC_ENQ, $urandom);
    wait_results_drained();
    write_capacity(5'd0);
    send_op(FUNC_DEQ, $urandom);
    send_op(FUNC_ENQ, $urandom);
    wait_results_drained();
    write_capacity(5'd31);
    send_op(FUNC_ENQ, $urandom);
  endtask

  // Phases alternate between filling and draining so full and empty are hit
  task automatic test_random_phases();
    int sent;
    int phase;
    int enq_bias;
    int unsigned pick;
    logic [CAP_W-1:0] cap;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_results_drained();
      case ($urandom_range(0, 5))
        0: cap = 5'd0;
        1: cap = 5'd1;
        2: cap = 5'(DEPTH);
        3: cap = 5'd31;
        default: cap = 5'($urandom_range(0, 31));
      endcase
      write_capacity(cap);
      enq_bias = (phase % 2 == 0) ? 75 : 25;
      repeat ($urandom_range(10, 50)) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) send_op(FUNC_QUERY, rand_word());
        else if (pick < 6) send_op(FUNC_RSVD, rand_word());
        else if (pick < enq_bias) send_op(FUNC_ENQ, rand_word());
        else send_op(FUNC_DEQ, rand_word());
        sent++;
      end
      phase++;
    end
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    wait_results_drained();
    write_capacity(CAP_RESET);
    for (int i = 0; i < 80; i++) begin
      if (($urandom_range(0, 99) < 80) == (i < 40)) send_op(FUNC_ENQ, rand_word());
      else send_op(FUNC_DEQ, rand_word());
    end
  endtask

  // Receiver: random stall bursts
  always @(posedge clk_i) begin
    if (no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < 15) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("result %0d: transfer with no result expected", result_num);
      end else begin
        next_expected = pending_results.pop_front();
        check_field("status", DATA_W'(next_expected.status), DATA_W'(out_data.status));
        check_field("out_value", next_expected.out_value, out_data.out_value);
        check_field("front_value", next_expected.front_value, out_data.front_value);
        check_field("rear_value", next_expected.rear_value, out_data.rear_value);
        check_field("count", DATA_W'(next_expected.count), DATA_W'(out_data.count));
      end
      result_num++;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("circular_fifo_queue test failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_all_slots();
    test_capacity_with_data();
    test_random_phases();
    test_back_to_back();
    wait_results_drained();
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("circular_fifo_queue test passed");
    end else begin
      $display("circular_fifo_queue test failed");
    end
    $finish;
  end

endmodule
